// ===== rtl/core/tsfc_pkg.sv =====
package tsfc_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int RES_W        = 10;
  localparam int SAMPLES      = 4;
  localparam int PROD_W       = SAMPLE_W + RES_W;
  localparam int QUOT_W       = RES_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int IN_DATA_W    = 2 * SAMPLES * SAMPLE_W;
  localparam int OUT_DATA_W   = 48;

  localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT = 12'd50;
  localparam logic [SAMPLE_W-1:0] VALID_MARGIN = 12'd30;
  localparam logic [SAMPLE_W-1:0] ADC_FULL     = 12'd4095;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_min;
    logic [SAMPLE_W-1:0] x_max;
    logic [SAMPLE_W-1:0] y_min;
    logic [SAMPLE_W-1:0] y_max;
    logic [RES_W-1:0]    width;
    logic [RES_W-1:0]    height;
    logic                swap;
    logic [1:0]          invert;
  } tsfc_cfg_t;

  localparam tsfc_cfg_t CFG_RESET = '{
    x_min:  12'd0,
    x_max:  12'd4095,
    y_min:  12'd0,
    y_max:  12'd4095,
    width:  10'd480,
    height: 10'd320,
    swap:   1'b0,
    invert: 2'b00
  };

  // filtered touch, handed from the front to the back
  typedef struct packed {
    logic                pressed;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] my;
  } tsfc_item_t;

endpackage

// ===== rtl/core/tsfc_front.sv =====
module tsfc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tsfc_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          push_valid,
  input  logic                          push_ready,
  output tsfc_pkg::tsfc_item_t          push_item
);
  import tsfc_pkg::*;

  typedef logic [SAMPLES-1:0][SAMPLE_W-1:0] quad_t;

  // middle pair of four values, larger one in the upper half
  function automatic logic [2*SAMPLE_W-1:0] mid_pair(input quad_t s);
    logic [SAMPLE_W-1:0] h0, l0, h1, l1, m0, m1;
    h0 = (s[0] > s[1]) ? s[0] : s[1];
    l0 = (s[0] > s[1]) ? s[1] : s[0];
    h1 = (s[2] > s[3]) ? s[2] : s[3];
    l1 = (s[2] > s[3]) ? s[3] : s[2];
    m0 = (h0 > h1) ? h1 : h0;
    m1 = (l0 > l1) ? l0 : l1;
    return (m0 > m1) ? {m0, m1} : {m1, m0};
  endfunction

  logic                  a_v_r;
  logic [SAMPLE_W-1:0]   xh_r, xl_r, yh_r, yl_r;
  logic                  b_v_r;
  tsfc_item_t            b_item_r;
  tsfc_item_t            b_item_nxt;
  logic                  ready_a, ready_b;
  quad_t                 xs, ys;
  logic [SAMPLE_W:0]     sum_x, sum_y;
  logic [SAMPLE_W-1:0]   mean_x, mean_y;
  logic                  reject, in_window;

  assign xs = in_tdata[SAMPLES*SAMPLE_W-1:0];
  assign ys = in_tdata[IN_DATA_W-1:SAMPLES*SAMPLE_W];

  assign ready_b   = !b_v_r || push_ready;
  assign ready_a   = !a_v_r || ready_b;
  assign in_tready = ready_a;

  always_comb begin
    sum_x  = {1'b0, xh_r} + {1'b0, xl_r};
    sum_y  = {1'b0, yh_r} + {1'b0, yl_r};
    mean_x = sum_x[SAMPLE_W:1];
    mean_y = sum_y[SAMPLE_W:1];
    reject = ((xh_r - xl_r) > SPREAD_LIMIT) || ((yh_r - yl_r) > SPREAD_LIMIT);
    in_window = (mean_x > VALID_MARGIN) && (mean_y > VALID_MARGIN) &&
                (mean_x < (ADC_FULL - VALID_MARGIN)) &&
                (mean_y < (ADC_FULL - VALID_MARGIN));
    if (reject) begin
      b_item_nxt = '0;
    end else begin
      b_item_nxt.pressed = in_window;
      b_item_nxt.mx      = mean_x;
      b_item_nxt.my      = mean_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (ready_a) a_v_r <= in_tvalid;
      if (ready_b) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_tvalid) begin
      {xh_r, xl_r} <= mid_pair(xs);
      {yh_r, yl_r} <= mid_pair(ys);
    end
    if (ready_b && a_v_r) b_item_r <= b_item_nxt;
  end

  assign push_valid = b_v_r;
  assign push_item  = b_item_r;

endmodule

// ===== rtl/core/tsfc_fifo.sv =====
module tsfc_fifo #(
  parameter int DEPTH = tsfc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  tsfc_pkg::tsfc_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output tsfc_pkg::tsfc_item_t pop_item
);
  import tsfc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsfc_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("fifo empty but pointers differ");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("fifo count did not follow push");

endmodule

// ===== rtl/core/tsfc_back.sv =====
module tsfc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tsfc_pkg::tsfc_cfg_t             cfg,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  tsfc_pkg::tsfc_item_t            pop_item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tsfc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import tsfc_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] off;
    logic [SAMPLE_W-1:0] span;
    logic                nz;
  } prep_t;

  typedef struct packed {
    logic                pressed;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] my;
    prep_t               ax;
    prep_t               ay;
  } prep_lane_t;

  typedef struct packed {
    logic [PROD_W-1:0]   rem;
    logic [SAMPLE_W-1:0] den;
    logic [QUOT_W-1:0]   quo;
    logic                zero;
    logic                sat;
  } div_t;

  typedef struct packed {
    logic                pressed;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] my;
    div_t                dx;
    div_t                dy;
  } lane_t;

  function automatic prep_t prep_axis(input logic [SAMPLE_W-1:0] raw,
                                      input logic [SAMPLE_W-1:0] lo,
                                      input logic [SAMPLE_W-1:0] hi);
    prep_t p;
    p.off  = (raw > lo) ? raw - lo : '0;
    p.span = hi - lo;
    p.nz   = (hi > lo);
    return p;
  endfunction

  // saturates when off >= span: the quotient then reaches the resolution
  function automatic div_t mul_axis(input prep_t p, input logic [RES_W-1:0] res);
    div_t d;
    d.rem  = PROD_W'(p.off) * PROD_W'(res);
    d.den  = p.span;
    d.quo  = '0;
    d.zero = !p.nz;
    d.sat  = (p.off >= p.span);
    return d;
  endfunction

  // one restoring step, quotient bits enter from the bottom MSB first
  function automatic div_t div_step(input div_t d, input int sh);
    div_t              r;
    logic [PROD_W-1:0] trial;
    r     = d;
    trial = PROD_W'(d.den) << sh;
    if (d.rem >= trial) begin
      r.rem = d.rem - trial;
      r.quo = {d.quo[QUOT_W-2:0], 1'b1};
    end else begin
      r.quo = {d.quo[QUOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [RES_W-1:0] fin_axis(input div_t d,
                                                input logic [RES_W-1:0] res,
                                                input logic inv);
    logic [RES_W-1:0] s;
    if (d.zero)     s = '0;
    else if (d.sat) s = res;
    else            s = d.quo;
    return inv ? res - s : s;
  endfunction

  logic                  en;
  logic                  p_v_r;
  prep_lane_t            p_r;
  logic [QUOT_W:0]       lv_r;
  lane_t                 lane_r [QUOT_W+1];
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic [SAMPLE_W-1:0]   ax_raw, ay_raw;
  logic [RES_W-1:0]      px_fin, py_fin;

  // whole back end moves together; it holds only while a result waits
  assign en        = !out_valid_r || out_tready;
  assign pop_ready = en;

  assign ax_raw = cfg.swap ? pop_item.my : pop_item.mx;
  assign ay_raw = cfg.swap ? pop_item.mx : pop_item.my;

  assign px_fin = fin_axis(lane_r[QUOT_W].dx, cfg.width, cfg.invert[0]);
  assign py_fin = fin_axis(lane_r[QUOT_W].dy, cfg.height, cfg.invert[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      lv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_v_r       <= pop_valid;
      lv_r        <= {lv_r[QUOT_W-1:0], p_v_r};
      out_valid_r <= lv_r[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r.pressed <= pop_item.pressed;
      p_r.mx      <= pop_item.mx;
      p_r.my      <= pop_item.my;
      p_r.ax      <= prep_axis(ax_raw, cfg.x_min, cfg.x_max);
      p_r.ay      <= prep_axis(ay_raw, cfg.y_min, cfg.y_max);

      lane_r[0].pressed <= p_r.pressed;
      lane_r[0].mx      <= p_r.mx;
      lane_r[0].my      <= p_r.my;
      lane_r[0].dx      <= mul_axis(p_r.ax, cfg.width);
      lane_r[0].dy      <= mul_axis(p_r.ay, cfg.height);

      for (int k = 0; k < QUOT_W; k++) begin
        lane_r[k+1].pressed <= lane_r[k].pressed;
        lane_r[k+1].mx      <= lane_r[k].mx;
        lane_r[k+1].my      <= lane_r[k].my;
        lane_r[k+1].dx      <= div_step(lane_r[k].dx, QUOT_W - 1 - k);
        lane_r[k+1].dy      <= div_step(lane_r[k].dy, QUOT_W - 1 - k);
      end

      out_user_r <= lane_r[QUOT_W].pressed;
      out_data_r <= {4'b0, lane_r[QUOT_W].my, lane_r[QUOT_W].mx,
                     lane_r[QUOT_W].pressed ? py_fin : {RES_W{1'b0}},
                     lane_r[QUOT_W].pressed ? px_fin : {RES_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[2*RES_W-1:0] == '0))
    else $error("point nonzero on a released touch");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(lv_r[QUOT_W]))
    else $error("result appeared without a finished divide");

endmodule

// ===== rtl/core/touch_sample_filter_calibrate.sv =====
// Touch sample filter and calibration.
//
// Input stream (in_*): one item holds four raw X and four raw Y conversions.
// Each axis keeps the mean of its middle pair; a spread above 50 rejects the
// touch, and a mean outside 31..4064 marks it released. Pressed points are
// optionally swapped, offset, scaled to the screen and optionally inverted.
// Output stream (out_*): exactly one result per input item, in order.
// Config port (cfg_*): write only, one register per index; write while idle.
//
// On its way to out_tvalid an item passes two filter stages, one queue slot,
// offset, multiply, ten restoring divide steps (one quotient bit each) and
// the output register. One item is taken every cycle while in_tready is high.
// A stalled out_tready freezes the scaling pipeline; the four-entry queue and
// the filter stages keep taking items until they fill, then in_tready drops.
// Reset empties the pipeline and the queue and loads the default calibration.
module touch_sample_filter_calibrate #(
  parameter int QUEUE_DEPTH = tsfc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // x_sample0, x_sample1, x_sample2, x_sample3, y_sample0 .. y_sample3
  input  logic [tsfc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // point_x, point_y, filtered_x, filtered_y, zero pad
  output logic [tsfc_pkg::OUT_DATA_W-1:0] out_tdata,
  // pressed
  output logic                            out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsfc_pkg::SAMPLE_W-1:0]   cfg_wdata
);
  import tsfc_pkg::*;

  tsfc_cfg_t  cfg_r;
  logic       push_valid, push_ready;
  tsfc_item_t push_item;
  logic       pop_valid, pop_ready;
  tsfc_item_t pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_X_MIN:  cfg_r.x_min  <= cfg_wdata;
        REG_X_MAX:  cfg_r.x_max  <= cfg_wdata;
        REG_Y_MIN:  cfg_r.y_min  <= cfg_wdata;
        REG_Y_MAX:  cfg_r.y_max  <= cfg_wdata;
        REG_WIDTH:  cfg_r.width  <= cfg_wdata[RES_W-1:0];
        REG_HEIGHT: cfg_r.height <= cfg_wdata[RES_W-1:0];
        REG_SWAP:   cfg_r.swap   <= cfg_wdata[0];
        REG_INVERT: cfg_r.invert <= cfg_wdata[1:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  tsfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tsfc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tsfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/sv/tb_touch_sample_filter_calibrate.sv =====
`timescale 1ns / 1ps

module tb_touch_sample_filter_calibrate;
  import tsfc_pkg::*;

  localparam int HOLD_CYCLES = 220;
  localparam int STALL_LIMIT = 3000;
  localparam int END_CYCLES  = 40;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 98;
  localparam int MAX_REPORTS = 10;
  localparam int ROWS        = 17;

  typedef logic [0:SAMPLES-1][SAMPLE_W-1:0] axis_samples_t;

  typedef struct packed {
    logic                pressed;
    logic [RES_W-1:0]    px;
    logic [RES_W-1:0]    py;
    logic [SAMPLE_W-1:0] fx;
    logic [SAMPLE_W-1:0] fy;
  } touch_point_t;

  typedef struct packed {
    logic          typed;
    axis_samples_t xs;
    axis_samples_t ys;
    touch_point_t  want;
  } touch_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SAMPLE_W-1:0]   cfg_wdata;

  touch_point_t expected_points[$];
  tsfc_cfg_t    calib;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           sender_jitter;
  bit           ready_jitter;
  bit           hold_off_req;
  bit           hold_off_done = 1'b0;

  // rows marked typed carry a result worked out by hand for the reset calibration
  touch_row_t directed_rows [ROWS] = '{
    '{1'b1, '{12'd0, 12'd0, 12'd0, 12'd0}, '{12'd0, 12'd0, 12'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, 12'd0, 12'd0}},
    '{1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
      '{1'b0, 10'd0, 10'd0, 12'd4095, 12'd4095}},
    '{1'b1, '{12'd0, 12'd4095, 12'd0, 12'd4095}, '{12'd2000, 12'd2000, 12'd2000, 12'd2000},
      '{1'b0, 10'd0, 10'd0, 12'd0, 12'd0}},
    '{1'b1, '{12'd2000, 12'd2000, 12'd2000, 12'd2000}, '{12'd4095, 12'd0, 12'd4095, 12'd0},
      '{1'b0, 10'd0, 10'd0, 12'd0, 12'd0}},
    '{1'b0, '{12'd1000, 12'd1050, 12'd1000, 12'd1050},
      '{12'd2000, 12'd2000, 12'd2000, 12'd2000}, '0},
    '{1'b1, '{12'd1000, 12'd1051, 12'd1000, 12'd1051},
      '{12'd2000, 12'd2000, 12'd2000, 12'd2000}, '{1'b0, 10'd0, 10'd0, 12'd0, 12'd0}},
    '{1'b1, '{12'd2000, 12'd2000, 12'd2000, 12'd2000},
      '{12'd3000, 12'd3051, 12'd3000, 12'd3051}, '{1'b0, 10'd0, 10'd0, 12'd0, 12'd0}},
    '{1'b1, '{12'd30, 12'd30, 12'd30, 12'd30}, '{12'd2000, 12'd2000, 12'd2000, 12'd2000},
      '{1'b0, 10'd0, 10'd0, 12'd30, 12'd2000}},
    '{1'b0, '{12'd31, 12'd31, 12'd31, 12'd31}, '{12'd31, 12'd31, 12'd31, 12'd31}, '0},
    '{1'b1, '{12'd4065, 12'd4065, 12'd4065, 12'd4065},
      '{12'd2000, 12'd2000, 12'd2000, 12'd2000}, '{1'b0, 10'd0, 10'd0, 12'd4065, 12'd2000}},
    '{1'b0, '{12'd4064, 12'd4064, 12'd4064, 12'd4064},
      '{12'd4064, 12'd4064, 12'd4064, 12'd4064}, '0},
    '{1'b0, '{12'd101, 12'd100, 12'd100, 12'd101}, '{12'd0, 12'd4095, 12'd2047, 12'd2048}, '0},
    '{1'b0, '{12'd500, 12'd3000, 12'd510, 12'd0}, '{12'd7, 12'd2100, 12'd2090, 12'd4000}, '0},
    '{1'b0, '{12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA}, '{12'h555, 12'h555, 12'h555, 12'h555}, '0},
    '{1'b0, '{12'h555, 12'h555, 12'h555, 12'h555}, '{12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA}, '0},
    '{1'b1, '{12'd2000, 12'd2000, 12'd2000, 12'd2000}, '{12'd30, 12'd30, 12'd30, 12'd30},
      '{1'b0, 10'd0, 10'd0, 12'd2000, 12'd30}},
    '{1'b1, '{12'd2000, 12'd2000, 12'd2000, 12'd2000},
      '{12'd4065, 12'd4065, 12'd4065, 12'd4065}, '{1'b0, 10'd0, 10'd0, 12'd2000, 12'd4065}}
  };

  touch_sample_filter_calibrate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // descending sort; 0 when the middle pair spreads too far
  function automatic bit middle_pair_mean(input axis_samples_t s,
                                          output logic [SAMPLE_W-1:0] mean);
    logic [SAMPLE_W-1:0] v [SAMPLES];
    logic [SAMPLE_W-1:0] t;
    logic [SAMPLE_W:0]   sum;
    for (int i = 0; i < SAMPLES; i++) v[i] = s[i];
    for (int i = 0; i < SAMPLES; i++) begin
      for (int j = i + 1; j < SAMPLES; j++) begin
        if (v[j] > v[i]) begin
          t = v[i];
          v[i] = v[j];
          v[j] = t;
        end
      end
    end
    mean = '0;
    if (v[1] - v[2] > SPREAD_LIMIT) return 1'b0;
    sum = {1'b0, v[1]} + {1'b0, v[2]};
    mean = sum[SAMPLE_W:1];
    return 1'b1;
  endfunction

  function automatic logic [RES_W-1:0] scale_axis(input logic [SAMPLE_W-1:0] raw,
                                                  input logic [SAMPLE_W-1:0] lo,
                                                  input logic [SAMPLE_W-1:0] hi,
                                                  input logic [RES_W-1:0] res,
                                                  input bit inv);
    int unsigned off;
    int unsigned span;
    int unsigned scaled;
    off = (raw > lo) ? 32'(raw - lo) : 32'd0;
    scaled = 0;
    if (hi > lo) begin
      span = 32'(hi - lo);
      scaled = (off * 32'(res)) / span;
    end
    if (scaled > 32'(res)) scaled = 32'(res);
    if (inv) scaled = 32'(res) - scaled;
    return scaled[RES_W-1:0];
  endfunction

  function automatic touch_point_t filter_and_calibrate(input axis_samples_t xs,
                                                       input axis_samples_t ys);
    touch_point_t        p;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] my;
    logic [SAMPLE_W-1:0] ax;
    logic [SAMPLE_W-1:0] ay;
    bit                  ok_x;
    bit                  ok_y;
    p = '0;
    ok_x = middle_pair_mean(xs, mx);
    ok_y = middle_pair_mean(ys, my);
    if (!ok_x || !ok_y) return p;
    p.fx = mx;
    p.fy = my;
    if (mx > VALID_MARGIN && my > VALID_MARGIN &&
        mx < ADC_FULL - VALID_MARGIN && my < ADC_FULL - VALID_MARGIN) begin
      ax = calib.swap ? my : mx;
      ay = calib.swap ? mx : my;
      p.pressed = 1'b1;
      p.px = scale_axis(ax, calib.x_min, calib.x_max, calib.width, calib.invert[0]);
      p.py = scale_axis(ay, calib.y_min, calib.y_max, calib.height, calib.invert[1]);
    end
    return p;
  endfunction

  // kind 0: tight cluster, 1: middle pair near the spread limit, 2: noise
  function automatic axis_samples_t random_axis(input int kind);
    axis_samples_t       s;
    logic [SAMPLE_W-1:0] t;
    int unsigned         lo;
    int unsigned         w;
    int unsigned         d;
    int                  j;
    case (kind)
      0: begin
        case ($urandom_range(0, 5))
          0:       lo = $urandom_range(0, 60);
          1:       lo = $urandom_range(3990, 4045);
          default: lo = $urandom_range(0, 4045);
        endcase
        w = $urandom_range(0, 50);
        for (int i = 0; i < SAMPLES; i++) s[i] = SAMPLE_W'(lo + $urandom_range(0, w));
      end
      1: begin
        lo = $urandom_range(100, 3900);
        d = $urandom_range(44, 58);
        s[0] = SAMPLE_W'(lo - $urandom_range(0, 80));
        s[1] = SAMPLE_W'(lo);
        s[2] = SAMPLE_W'(lo + d);
        s[3] = SAMPLE_W'(lo + d + $urandom_range(0, 80));
      end
      default: begin
        for (int i = 0; i < SAMPLES; i++) s[i] = SAMPLE_W'($urandom_range(0, 4095));
      end
    endcase
    for (int i = SAMPLES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = s[i];
      s[i] = s[j];
      s[j] = t;
    end
    return s;
  endfunction

  task automatic send_touch(input axis_samples_t xs, input axis_samples_t ys,
                            input bit typed, input touch_point_t want);
    logic [IN_DATA_W-1:0] d;
    while (sender_jitter && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < SAMPLES; i++) begin
      d[i*SAMPLE_W +: SAMPLE_W] = xs[i];
      d[(SAMPLES+i)*SAMPLE_W +: SAMPLE_W] = ys[i];
    end
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_points.push_back(typed ? want : filter_and_calibrate(xs, ys));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_X_MIN:  calib.x_min  = val;
      REG_X_MAX:  calib.x_max  = val;
      REG_Y_MIN:  calib.y_min  = val;
      REG_Y_MAX:  calib.y_max  = val;
      REG_WIDTH:  calib.width  = val[RES_W-1:0];
      REG_HEIGHT: calib.height = val[RES_W-1:0];
      REG_SWAP:   calib.swap   = val[0];
      REG_INVERT: calib.invert = val[1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    touch_point_t got;
    touch_point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pressed = out_tuser;
      got.px = out_tdata[9:0];
      got.py = out_tdata[19:10];
      got.fx = out_tdata[31:20];
      got.fy = out_tdata[43:32];
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected item pressed=%0d x=%0d y=%0d fx=%0d fy=%0d",
                   $realtime, got.pressed, got.px, got.py, got.fx, got.fy);
      end else begin
        want = expected_points.pop_front();
        if (got.pressed !== want.pressed || got.px !== want.px || got.py !== want.py ||
            got.fx !== want.fx || got.fy !== want.fy) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: exp pressed=%0d x=%0d y=%0d fx=%0d fy=%0d, got %0d %0d %0d %0d %0d",
                     $realtime, want.pressed, want.px, want.py, want.fx, want.fy,
                     got.pressed, got.px, got.py, got.fx, got.fy);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side ready, with one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_tready <= !ready_jitter || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  initial begin
    tsfc_cfg_t     next_cal;
    axis_samples_t xs;
    axis_samples_t ys;
    int            pick;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    sender_jitter  = 1'b1;
    ready_jitter   = 1'b1;
    hold_off_req   = 1'b0;
    calib          = CFG_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_touch(directed_rows[i].xs, directed_rows[i].ys, directed_rows[i].typed,
                 directed_rows[i].want);

    for (int p = 1; p <= PHASES; p++) begin
      in_tvalid <= 1'b0;
      wait_drained();
      next_cal.x_min  = SAMPLE_W'($urandom_range(0, 1500));
      next_cal.x_max  = SAMPLE_W'($urandom_range(2500, 4095));
      next_cal.y_min  = SAMPLE_W'($urandom_range(0, 1500));
      next_cal.y_max  = SAMPLE_W'($urandom_range(2500, 4095));
      next_cal.width  = RES_W'($urandom_range(1, 1023));
      next_cal.height = RES_W'($urandom_range(1, 1023));
      next_cal.swap   = 1'($urandom_range(0, 1));
      next_cal.invert = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) begin
        next_cal.x_min = SAMPLE_W'($urandom_range(0, 4095));
        next_cal.y_max = SAMPLE_W'($urandom_range(0, 4095));
      end
      case (p)
        1: next_cal = '{12'd0, 12'd0, 12'd4095, 12'd0, 10'd1023, 10'd1023, 1'b1, 2'd3};
        2: next_cal = '{12'd4095, 12'd4095, 12'd0, 12'd4095, 10'd1, 10'd1, 1'b0, 2'd1};
        3: begin
          // zero resolution on both axes
          next_cal.width  = '0;
          next_cal.height = '0;
          next_cal.swap   = 1'b1;
          next_cal.invert = 2'd3;
        end
        4: next_cal = '{12'd2000, 12'd2010, 12'd1000, 12'd1001, 10'd1023, 10'd1023, 1'b0, 2'd2};
        5: next_cal = '{12'd0, 12'd4095, 12'd0, 12'd4095, 10'd1023, 10'd1023, 1'b0, 2'd0};
        default: ;
      endcase
      write_reg(REG_X_MIN, next_cal.x_min);
      write_reg(REG_X_MAX, next_cal.x_max);
      write_reg(REG_Y_MIN, next_cal.y_min);
      write_reg(REG_Y_MAX, next_cal.y_max);
      write_reg(REG_WIDTH, SAMPLE_W'(next_cal.width));
      write_reg(REG_HEIGHT, SAMPLE_W'(next_cal.height));
      write_reg(REG_SWAP, SAMPLE_W'(next_cal.swap));
      write_reg(REG_INVERT, SAMPLE_W'(next_cal.invert));
      cfg_wr_en <= 1'b0;

      sender_jitter = (p != 8);
      ready_jitter  = (p != 8);
      // fill the block up behind a stalled receiver
      if (p == 6) hold_off_req = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          xs = random_axis(0);
          ys = random_axis(0);
        end else if (pick < 86) begin
          xs = random_axis($urandom_range(0, 1));
          ys = random_axis($urandom_range(0, 1));
        end else begin
          xs = random_axis(2);
          ys = random_axis($urandom_range(0, 2));
        end
        send_touch(xs, ys, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
